// ----- rtl/chr_pkg.sv -----
// Shared types and codes for the consistent hash ring table.
`default_nettype none
package chr_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] hash;
    logic [8:0]  position;
    logic [15:0] server_tag;
    logic [15:0] replica_number;
  } in_t;

  typedef struct packed {
    logic [7:0]  found_index;
    logic [15:0] owner_tag;
    logic [15:0] owner_replica;
    logic [7:0]  next_index;
    logic [8:0]  entry_count;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [15:0] tag;
    logic [15:0] replica;
  } entry_t;

  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/chr_cell.sv -----
// One ring slot: holds an entry, shifts with its neighbors and compares its hash.
`default_nettype none
module chr_cell #(
  parameter int CNT_W = 9,
  parameter int IDX   = 0
) (
  input  wire                  clk,
  input  chr_pkg::cell_ctl_t   ctl,
  input  wire [CNT_W-1:0]      pos,
  input  wire [CNT_W-1:0]      count,
  input  wire [31:0]           key,
  input  chr_pkg::entry_t      new_entry,
  input  chr_pkg::entry_t      left,
  input  chr_pkg::entry_t      right,
  output chr_pkg::entry_t      entry,
  output logic                 hit
);

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

  chr_pkg::entry_t entry_r;
  chr_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en) begin
      if (MY_IDX == pos) begin
        entry_nxt = new_entry;
      end else if ((MY_IDX > pos) && (MY_IDX <= count)) begin
        entry_nxt = left;
      end
    end else if (ctl.del_en) begin
      // Only slots below the last valid entry pull from the right.
      if ((MY_IDX >= pos) && (MY_NEXT < count)) begin
        entry_nxt = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign hit   = (key <= entry_r.hash);

endmodule
`default_nettype wire

// ----- rtl/consistent_hash_ring_table_unit.sv -----
// Top level of the consistent hash ring table: slot chain and operation sequencer.
//
//  channel  ports                    handshake
//  input    start, busy, in_item     accepted when start && !busy
//  result   out_valid, out_result    one-cycle strobe, always taken
//
// Insert and delete are accepted into S_EXEC, where the slots at and above the position
// shift together and the result is registered. A lookup on a non-empty table
// binary-searches in S_SEARCH over the slot hit bits, one probe per cycle.
// Reset clears the entry count and sequencer; slot contents stay undefined.
// The result strobe cannot be stalled, so busy only covers the work itself.
`default_nettype none
module consistent_hash_ring_table_unit #(
  parameter int RING_DEPTH = 256
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  chr_pkg::in_t     in_item,
  output logic             out_valid,
  output chr_pkg::out_t    out_result
);

  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SEARCH} state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hi_r, hi_nxt;
  chr_pkg::in_t        req_r;
  chr_pkg::out_t       out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  chr_pkg::cell_ctl_t  ctl;
  chr_pkg::entry_t     new_entry;
  chr_pkg::entry_t     slot_q [RING_DEPTH];
  logic [RING_DEPTH-1:0] hits;
  logic [CNT_W-1:0]    pos_c;

  assign pos_c = CNT_W'(req_r.position);
  assign new_entry = '{hash: req_r.hash, tag: req_r.server_tag,
                       replica: req_r.replica_number};

  genvar gi;
  generate
    for (gi = 0; gi < RING_DEPTH; gi++) begin : g_slot
      chr_pkg::entry_t left_e;
      chr_pkg::entry_t right_e;
      if (gi == 0) begin : g_first
        assign left_e = '0;
      end else begin : g_mid_l
        assign left_e = slot_q[gi-1];
      end
      if (gi == RING_DEPTH - 1) begin : g_last
        assign right_e = '0;
      end else begin : g_mid_r
        assign right_e = slot_q[gi+1];
      end
      chr_cell #(.CNT_W(CNT_W), .IDX(gi)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .pos       (pos_c),
        .count     (count_r),
        .key       (req_r.hash),
        .new_entry (new_entry),
        .left      (left_e),
        .right     (right_e),
        .entry     (slot_q[gi]),
        .hit       (hits[gi])
      );
    end
  endgenerate

  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] found_c;
  logic [CNT_W-1:0] next_c;
  logic [IDX_W-1:0] found_idx;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;

  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign found_c   = (lo_r >= count_r) ? '0 : lo_r;
  assign found_idx = found_c[IDX_W-1:0];
  assign next_c    = ((found_c + CNT_W'(1)) >= count_r) ? '0 : (found_c + CNT_W'(1));
  assign pos_w     = CMP_W'(req_r.position);
  assign cnt_w     = CMP_W'(count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    ctl           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_nxt   = '0;
        state_nxt = S_IDLE;
        priority if (req_r.operation == chr_pkg::OP_LOOKUP) begin
          if (count_r == '0) begin
            out_nxt.status = chr_pkg::ST_EMPTY;
            out_valid_nxt  = 1'b1;
          end else begin
            lo_nxt    = '0;
            hi_nxt    = count_r;
            state_nxt = S_SEARCH;
          end
        end else if (req_r.operation == chr_pkg::OP_INSERT) begin
          out_valid_nxt = 1'b1;
          priority if (count_r == FULL_CNT) begin
            out_nxt.status = chr_pkg::ST_FULL;
          end else if (pos_w > cnt_w) begin
            out_nxt.status = chr_pkg::ST_RANGE;
          end else begin
            ctl.ins_en = 1'b1;
            count_nxt  = count_r + CNT_W'(1);
          end
        end else if (req_r.operation == chr_pkg::OP_DELETE) begin
          out_valid_nxt = 1'b1;
          priority if (count_r == '0) begin
            out_nxt.status = chr_pkg::ST_EMPTY;
          end else if (pos_w >= cnt_w) begin
            out_nxt.status = chr_pkg::ST_RANGE;
          end else begin
            ctl.del_en = 1'b1;
            count_nxt  = count_r - CNT_W'(1);
          end
        end else begin
          out_valid_nxt = 1'b1;
        end
        out_nxt.entry_count = 9'(count_nxt);
      end
      S_SEARCH: begin
        if (lo_r < hi_r) begin
          if (hits[mid[IDX_W-1:0]]) begin
            hi_nxt = mid;
          end else begin
            lo_nxt = mid + CNT_W'(1);
          end
        end else begin
          out_nxt.found_index   = 8'(found_c);
          out_nxt.owner_tag     = slot_q[found_idx].tag;
          out_nxt.owner_replica = slot_q[found_idx].replica;
          out_nxt.next_index    = 8'(next_c);
          out_nxt.entry_count   = 9'(count_r);
          out_nxt.status        = chr_pkg::ST_OK;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    out_r <= out_nxt;
    if (state_r == S_IDLE) begin
      req_r <= in_item;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above ring depth");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != S_IDLE))
    else $error("result strobe without a transaction in progress");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == chr_pkg::ST_FULL) |-> (count_r == FULL_CNT))
    else $error("full status reported on a table that is not full");

  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (hi_r <= count_r && lo_r <= hi_r))
    else $error("search window left the valid entries");

endmodule
`default_nettype wire
